### rtl/core/slpa_pkg.sv
// Shared types and codes for the slot pool lifecycle allocator.
// Used by the front, back and top level files; depends on nothing.
package slpa_pkg;

    // Request kinds.
    localparam logic [2:0] KIND_ACQUIRE        = 3'd0;
    localparam logic [2:0] KIND_RELEASE_EMPTY  = 3'd1;
    localparam logic [2:0] KIND_INSTALL        = 3'd2;
    localparam logic [2:0] KIND_MARK_CLOSING   = 3'd3;
    localparam logic [2:0] KIND_RELEASE_CLOSED = 3'd4;
    localparam logic [2:0] KIND_POISON         = 3'd5;
    localparam logic [2:0] KIND_INSPECT        = 3'd6;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_BAD       = 2'd3;

    // Slot lifecycle states.
    localparam logic [2:0] SLOT_FREE      = 3'd0;
    localparam logic [2:0] SLOT_LEASED    = 3'd1;
    localparam logic [2:0] SLOT_POPULATED = 3'd2;
    localparam logic [2:0] SLOT_CLOSING   = 3'd3;
    localparam logic [2:0] SLOT_POISONED  = 3'd4;

    // Field widths and packed bus widths.
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 16;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 56;

    // A classified request as it waits in the queue.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
    } item_t;

endpackage

### rtl/core/slot_pool_lifecycle_allocator.sv
// Top level of the slot pool lifecycle allocator.
// Depends on slpa_pkg, slpa_front, slpa_back and slpa_ram.
//
// Usage:
// Requests arrive on the s_ stream channel (kind and slot index in s_tdata);
// one result transaction per request leaves on the m_ stream channel with
// status, granted slot, addressed slot state, free count and poison count.
// The front queues up to two classified requests; the back executes each as
// a read step and an execute step: ST_READ reads the state, position and
// stack-top tables, and ST_EXEC writes them back and loads the result
// register. The back takes no new request until the last is written back.
// After reset the back runs a clearing pass through all SLOTS entries of the
// tables; s_tready stays low until it finishes. When the receiver stalls, the
// result register holds, the back waits with its next request, and the front
// keeps accepting until its two-entry queue is full.
module slot_pool_lifecycle_allocator #(
    parameter int SLOTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata fields from bit 0: kind[2:0], slot[18:3], zero fill[23:19].
    input  logic [slpa_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata fields from bit 0: status[1:0], granted_slot[17:2],
    // slot_status[20:18], free_slots[36:21], poisoned_total[52:37], zero[55:53].
    output logic [slpa_pkg::OUT_W-1:0] m_tdata
);

    logic            init_busy;
    logic            q_valid;
    logic            q_pop;
    slpa_pkg::item_t q_item;

    slpa_front #(.SLOTS(SLOTS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .init_busy(init_busy),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    slpa_back #(.SLOTS(SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .init_busy(init_busy),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // No transaction is taken while the tables are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_tready)
        else $error("request accepted during clearing pass");

    // Free and poisoned slots together never exceed the pool size; poisoned slots are never on the free stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[36:21]} + {1'b0, m_tdata[52:37]} <= 17'(SLOTS)))
        else $error("free plus poisoned exceeds pool size");

    // Exhausted is only reported with an empty stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == slpa_pkg::STATUS_EXHAUSTED) |-> (m_tdata[36:21] == 16'd0))
        else $error("exhausted with free slots left");

    // The back never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

### rtl/core/slpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for all slot pool tables; depends on nothing.
module slpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old data; read data is registered.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/slpa_front.sv
// Front end: accepts requests, checks the slot range and queues them.
// Depends on slpa_pkg.
module slpa_front #(
    parameter int SLOTS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     init_busy,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [slpa_pkg::IN_W-1:0] s_tdata,
    output logic                     q_valid,
    output slpa_pkg::item_t          q_item,
    input  logic                     q_pop
);

    slpa_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    slpa_pkg::item_t in_item;
    logic            push;

    // Classify the incoming transaction.
    always_comb begin
        in_item.kind     = s_tdata[2:0];
        in_item.slot     = s_tdata[18:3];
        in_item.in_range = ({1'b0, s_tdata[18:3]} < 17'(SLOTS));
    end

    assign s_tready = !init_busy && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // Queue pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/slpa_back.sv
// Back end: carries out queued requests against the state, stack and position
// tables, and holds the result register. Depends on slpa_pkg and slpa_ram.
module slpa_back #(
    parameter int SLOTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    output logic                      init_busy,
    input  logic                      q_valid,
    input  slpa_pkg::item_t           q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [slpa_pkg::OUT_W-1:0] m_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   depth_reg, depth_next;
    logic [CW-1:0]   poison_reg, poison_next;
    logic            m_valid_reg, m_valid_next;
    logic [slpa_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    logic            st_we, sk_we, ps_we;
    logic [IW-1:0]   st_waddr, sk_waddr, ps_waddr;
    logic [2:0]      st_wdata;
    logic [IW-1:0]   sk_wdata, ps_wdata;
    logic [2:0]      cur;
    logic [IW-1:0]   top, pos;
    logic [IW-1:0]   sidx, top_addr;
    logic            commit;
    logic [1:0]      status;
    logic [IW-1:0]   granted;
    logic [2:0]      shown;

    assign sidx     = q_item.slot[IW-1:0];
    assign top_addr = IW'(depth_reg - CW'(1));

    slpa_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_state_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(sidx), .rdata(cur)
    );

    slpa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack_ram (
        .aclk(aclk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(top_addr), .rdata(top)
    );

    slpa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_pos_ram (
        .aclk(aclk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .raddr(sidx), .rdata(pos)
    );

    assign init_busy = (state_reg == ST_INIT);
    assign commit    = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign q_pop     = commit;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Request execution and table writes.
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        depth_next   = depth_reg;
        poison_next  = poison_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        st_we = 1'b0; st_waddr = sidx; st_wdata = slpa_pkg::SLOT_FREE;
        sk_we = 1'b0; sk_waddr = pos;  sk_wdata = top;
        ps_we = 1'b0; ps_waddr = top;  ps_wdata = pos;
        status  = slpa_pkg::STATUS_OK;
        granted = '0;
        shown   = cur;

        if (q_item.kind == slpa_pkg::KIND_ACQUIRE) begin
            if (depth_reg == '0) begin
                status = slpa_pkg::STATUS_EXHAUSTED;
                shown  = slpa_pkg::SLOT_FREE;
            end else begin
                granted    = top;
                shown      = slpa_pkg::SLOT_LEASED;
                st_we      = 1'b1;
                st_waddr   = top;
                st_wdata   = slpa_pkg::SLOT_LEASED;
                depth_next = depth_reg - CW'(1);
            end
        end else if (!q_item.in_range) begin
            status = slpa_pkg::STATUS_RANGE;
            shown  = slpa_pkg::SLOT_FREE;
        end else begin
            unique case (q_item.kind)
                slpa_pkg::KIND_RELEASE_EMPTY, slpa_pkg::KIND_RELEASE_CLOSED: begin
                    if (cur != ((q_item.kind == slpa_pkg::KIND_RELEASE_EMPTY) ?
                                slpa_pkg::SLOT_LEASED : slpa_pkg::SLOT_CLOSING)) begin
                        status = slpa_pkg::STATUS_BAD;
                    end else begin
                        st_we      = 1'b1;
                        st_wdata   = slpa_pkg::SLOT_FREE;
                        shown      = slpa_pkg::SLOT_FREE;
                        ps_we      = 1'b1;
                        ps_waddr   = sidx;
                        ps_wdata   = IW'(depth_reg);
                        sk_we      = 1'b1;
                        sk_waddr   = IW'(depth_reg);
                        sk_wdata   = sidx;
                        depth_next = depth_reg + CW'(1);
                    end
                end
                slpa_pkg::KIND_INSTALL: begin
                    if (cur != slpa_pkg::SLOT_FREE) begin
                        status = slpa_pkg::STATUS_BAD;
                    end else begin
                        st_we      = 1'b1;
                        st_wdata   = slpa_pkg::SLOT_POPULATED;
                        shown      = slpa_pkg::SLOT_POPULATED;
                        // Move the last stack entry into the vacated position.
                        sk_we      = (top != sidx);
                        ps_we      = (top != sidx);
                        depth_next = depth_reg - CW'(1);
                    end
                end
                slpa_pkg::KIND_MARK_CLOSING: begin
                    if (cur != slpa_pkg::SLOT_POPULATED) begin
                        status = slpa_pkg::STATUS_BAD;
                    end else begin
                        st_we    = 1'b1;
                        st_wdata = slpa_pkg::SLOT_CLOSING;
                        shown    = slpa_pkg::SLOT_CLOSING;
                    end
                end
                slpa_pkg::KIND_POISON: begin
                    if (cur == slpa_pkg::SLOT_FREE) begin
                        status = slpa_pkg::STATUS_BAD;
                    end else if (cur != slpa_pkg::SLOT_POISONED) begin
                        st_we       = 1'b1;
                        st_wdata    = slpa_pkg::SLOT_POISONED;
                        shown       = slpa_pkg::SLOT_POISONED;
                        poison_next = poison_reg + CW'(1);
                    end
                end
                default: begin
                    // Inspect and the unused kind leave everything as it is.
                end
            endcase
        end

        unique case (state_reg)
            ST_INIT: begin
                // Clearing pass: slot i free, stack and position entries hold i.
                st_we = 1'b1; st_waddr = clr_reg; st_wdata = slpa_pkg::SLOT_FREE;
                sk_we = 1'b1; sk_waddr = clr_reg; sk_wdata = clr_reg;
                ps_we = 1'b1; ps_waddr = clr_reg; ps_wdata = clr_reg;
                depth_next  = depth_reg;
                poison_next = poison_reg;
                clr_next    = clr_reg + IW'(1);
                if (clr_reg == IW'(SLOTS - 1)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                st_we = 1'b0; sk_we = 1'b0; ps_we = 1'b0;
                depth_next  = depth_reg;
                poison_next = poison_reg;
                if (q_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next   = ST_READ;
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000,
                                    16'(poison_next),
                                    16'(depth_next),
                                    shown,
                                    16'(granted),
                                    status};
                end else begin
                    st_we = 1'b0; sk_we = 1'b0; ps_we = 1'b0;
                    depth_next  = depth_reg;
                    poison_next = poison_reg;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            depth_reg   <= CW'(SLOTS);
            poison_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            depth_reg   <= depth_next;
            poison_reg  <= poison_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
